// ----- design/vwsf_pkg.sv -----
package vwsf_pkg;

    // default field widths
    localparam int COORD_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // fixed widths
    localparam int SUM_W  = 32;
    localparam int CFG_W  = 15;
    localparam int NUM_CFG = 7;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // divider: one quotient bit per cycle over the whole sum
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_MERGE = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_PAR_TOL   = 3'd0;
    localparam logic [2:0] CFG_ORTH_TOL  = 3'd1;
    localparam logic [2:0] CFG_WALL_THK  = 3'd2;
    localparam logic [2:0] CFG_ORTH_MRG  = 3'd3;
    localparam logic [2:0] CFG_PAR_MRG   = 3'd4;
    localparam logic [2:0] CFG_SMALL_THR = 3'd5;
    localparam logic [2:0] CFG_SMALL_LEN = 3'd6;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
        15'd100, 15'd50, 15'd20, 15'd100, 15'd200, 15'd50, 15'd300
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIVIDE,
        ST_MULT,
        ST_FLAG
    } t_state;

endpackage

// ----- design/vwsf_if.sv -----
interface vwsf_in_if #(
    parameter int COORD_WIDTH = vwsf_pkg::COORD_WIDTH_DEF,
    parameter int COUNT_WIDTH = vwsf_pkg::COUNT_WIDTH_DEF
);
    logic                             valid;
    logic                             ready;
    logic [1:0]                       opcode;
    logic signed [COORD_WIDTH-1:0]    point_x;
    logic signed [COORD_WIDTH-1:0]    point_y;
    logic signed [COORD_WIDTH-1:0]    other_low_y;
    logic signed [COORD_WIDTH-1:0]    other_high_y;
    logic signed [COORD_WIDTH-1:0]    other_x_mean;
    logic signed [vwsf_pkg::SUM_W-1:0] other_x_sum;
    logic [COUNT_WIDTH-1:0]           other_count;

    modport source (
        output valid, opcode, point_x, point_y, other_low_y, other_high_y,
               other_x_mean, other_x_sum, other_count,
        input  ready
    );
    modport sink (
        input  valid, opcode, point_x, point_y, other_low_y, other_high_y,
               other_x_mean, other_x_sum, other_count,
        output ready
    );
endinterface

interface vwsf_out_if #(
    parameter int COORD_WIDTH = vwsf_pkg::COORD_WIDTH_DEF,
    parameter int COUNT_WIDTH = vwsf_pkg::COUNT_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic signed [COORD_WIDTH-1:0] seg_low_y;
    logic signed [COORD_WIDTH-1:0] seg_high_y;
    logic signed [COORD_WIDTH-1:0] seg_x;
    logic [COUNT_WIDTH-1:0]        seg_count;
    logic                          is_small;

    modport source (
        output valid, accepted, seg_low_y, seg_high_y, seg_x, seg_count, is_small,
        input  ready
    );
    modport sink (
        input  valid, accepted, seg_low_y, seg_high_y, seg_x, seg_count, is_small,
        output ready
    );
endinterface

// ----- design/vertical_wall_segment_fitter_core.sv -----
// idle takes a beat, eval tests it, an accepted add or merge runs the restoring
//   divider (one quotient bit per cycle of the 32-bit x sum); start, rejected items
//   and the unused opcode skip it; then mult, and flag loads the result register
//   once a held result is taken; no new beat is taken until back in idle
// reset: synchronous active-low i_rst_n clears the segment, reloads register defaults
module vertical_wall_segment_fitter_core #(
    parameter int COORD_WIDTH = vwsf_pkg::COORD_WIDTH_DEF,
    parameter int COUNT_WIDTH = vwsf_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    vwsf_in_if.sink                       i_pt,
    vwsf_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vwsf_pkg::APB_AW-1:0]   paddr,
    input  logic [vwsf_pkg::APB_DW-1:0]   pwdata,
    output logic [vwsf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int SUM_W  = vwsf_pkg::SUM_W;
    localparam int CFG_W  = vwsf_pkg::CFG_W;
    localparam int STEP_W = vwsf_pkg::STEP_W;
    // window compares: coordinate difference doubled, plus margin for sign
    localparam int WIDE_W  = ((COORD_WIDTH + 2 > CFG_W + 2) ? COORD_WIDTH + 2 : CFG_W + 2) + 2;
    localparam int PROD_W  = CFG_W + COUNT_WIDTH;
    localparam int SMALL_W = ((WIDE_W > PROD_W + 1) ? WIDE_W : PROD_W + 1) + 1;
    localparam logic signed [SUM_W:0] Q_MAX =
        (SUM_W+1)'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W:0] Q_MIN = -Q_MAX - 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(vwsf_pkg::DIV_STEPS - 1);

    // ------------------------------------------------------------------
    // configuration registers, apb access phase writes
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_cfg [vwsf_pkg::NUM_CFG];
    logic [2:0]       w_cfg_idx;
    logic             w_cfg_wr;
    logic             w_cfg_hit;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[vwsf_pkg::APB_AW-1:2];
    assign w_cfg_hit = (w_cfg_idx < 3'(vwsf_pkg::NUM_CFG));
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_cfg_hit;
    assign prdata    = w_cfg_hit ? vwsf_pkg::APB_DW'(r_cfg[w_cfg_idx]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= vwsf_pkg::CFG_RESET;
        end else if (w_cfg_wr) begin
            r_cfg[w_cfg_idx] <= pwdata[CFG_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    vwsf_pkg::t_state r_state, n_state;
    logic             w_in_beat;
    logic             w_load_out;
    logic             r_div;        // mean needs the divider
    logic             n_div;
    logic             r_out_valid;
    logic [STEP_W-1:0] r_step;

    assign w_in_beat = i_pt.valid && i_pt.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vwsf_pkg::ST_IDLE:   if (w_in_beat) n_state = vwsf_pkg::ST_EVAL;
            vwsf_pkg::ST_EVAL:   n_state = n_div ? vwsf_pkg::ST_DIVIDE : vwsf_pkg::ST_MULT;
            vwsf_pkg::ST_DIVIDE: if (r_step == LAST_STEP) n_state = vwsf_pkg::ST_MULT;
            vwsf_pkg::ST_MULT:   n_state = vwsf_pkg::ST_FLAG;
            vwsf_pkg::ST_FLAG:   if (w_load_out) n_state = vwsf_pkg::ST_IDLE;
            default:             n_state = vwsf_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: input ready, result register load
    always_comb begin
        i_pt.ready = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            vwsf_pkg::ST_IDLE: i_pt.ready = 1'b1;
            vwsf_pkg::ST_FLAG: w_load_out = !r_out_valid || o_res.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vwsf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // captured input beat
    // ------------------------------------------------------------------
    logic [1:0]                    r_op;
    logic signed [COORD_WIDTH-1:0] r_px, r_py, r_olo, r_ohi, r_omean;
    logic signed [SUM_W-1:0]       r_osum;
    logic [COUNT_WIDTH-1:0]        r_ocnt;

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_op    <= i_pt.opcode;
            r_px    <= i_pt.point_x;
            r_py    <= i_pt.point_y;
            r_olo   <= i_pt.other_low_y;
            r_ohi   <= i_pt.other_high_y;
            r_omean <= i_pt.other_x_mean;
            r_osum  <= i_pt.other_x_sum;
            r_ocnt  <= i_pt.other_count;
        end
    end

    // ------------------------------------------------------------------
    // segment state
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] r_low, r_high, r_mean;
    logic signed [SUM_W-1:0]       r_sum;
    logic [COUNT_WIDTH-1:0]        r_pt;
    logic                          r_acc;

    // ------------------------------------------------------------------
    // evaluation: window tests and merge tests on the captured beat
    // ------------------------------------------------------------------
    logic signed [WIDE_W-1:0] w_low, w_high, w_py, w_ptol, w_pmrg;
    logic signed [COORD_WIDTH:0] w_dx, w_dm;
    logic [COORD_WIDTH:0]     w_adx, w_adm;
    logic [COORD_WIDTH+1:0]   w_x2;
    logic [CFG_W+1:0]         w_xlim;
    logic [COUNT_WIDTH:0]     w_cnt_sum;
    logic signed [COORD_WIDTH-1:0] w_lower_top, w_upper_bottom;
    logic                     w_add_ok, w_merge_ok, w_gap_bad;
    logic signed [SUM_W:0]    w_addend, w_sum_wide;
    logic signed [SUM_W-1:0]  w_sum_sat;

    logic signed [COORD_WIDTH-1:0] n_low, n_high, n_mean;
    logic signed [SUM_W-1:0]       n_sum;
    logic [COUNT_WIDTH-1:0]        n_pt;
    logic                          n_acc;

    always_comb begin
        w_low  = WIDE_W'(r_low);
        w_high = WIDE_W'(r_high);
        w_py   = WIDE_W'(r_py);
        w_ptol = WIDE_W'({1'b0, r_cfg[vwsf_pkg::CFG_PAR_TOL]});
        w_pmrg = WIDE_W'({1'b0, r_cfg[vwsf_pkg::CFG_PAR_MRG]});

        // half wall thickness kept exact by doubling both sides
        w_dx   = {r_px[COORD_WIDTH-1], r_px} - {r_mean[COORD_WIDTH-1], r_mean};
        w_adx  = w_dx[COORD_WIDTH] ? $unsigned(-w_dx) : $unsigned(w_dx);
        w_x2   = {w_adx, 1'b0};
        w_xlim = {2'b00, r_cfg[vwsf_pkg::CFG_WALL_THK]}
               + {1'b0, r_cfg[vwsf_pkg::CFG_ORTH_TOL], 1'b0};

        w_add_ok = (r_pt != '0) && (r_pt != '1)
                && (w_py >= w_low - w_ptol) && (w_py <= w_high + w_ptol)
                && (WIDE_W'(w_x2) <= WIDE_W'(w_xlim));

        // combined count must not carry out of the count width
        w_cnt_sum = {1'b0, r_pt} + {1'b0, r_ocnt};
        w_dm      = {r_omean[COORD_WIDTH-1], r_omean} - {r_mean[COORD_WIDTH-1], r_mean};
        w_adm     = w_dm[COORD_WIDTH] ? $unsigned(-w_dm) : $unsigned(w_dm);
        w_merge_ok = (r_pt != '0) && (r_ocnt != '0) && !w_cnt_sum[COUNT_WIDTH]
                  && (WIDE_W'(w_adm) <= WIDE_W'(r_cfg[vwsf_pkg::CFG_ORTH_MRG]));

        // y gap between disjoint segments
        if (r_low > r_olo) begin
            w_lower_top    = r_ohi;
            w_upper_bottom = r_low;
        end else begin
            w_lower_top    = r_high;
            w_upper_bottom = r_olo;
        end
        w_gap_bad = (w_lower_top < w_upper_bottom)
                 && (WIDE_W'(w_upper_bottom) - WIDE_W'(w_lower_top) > w_pmrg);

        // saturating sum update
        w_addend   = (r_op == vwsf_pkg::OP_ADD) ? (SUM_W+1)'(r_px) : (SUM_W+1)'(r_osum);
        w_sum_wide = (SUM_W+1)'(r_sum) + w_addend;
        if (w_sum_wide[SUM_W] != w_sum_wide[SUM_W-1]) begin
            w_sum_sat = w_sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                          : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_sum_sat = w_sum_wide[SUM_W-1:0];
        end

        n_low  = r_low;
        n_high = r_high;
        n_mean = r_mean;
        n_sum  = r_sum;
        n_pt   = r_pt;
        n_acc  = 1'b0;
        n_div  = 1'b0;
        case (r_op)
            vwsf_pkg::OP_START: begin
                n_low  = r_py;
                n_high = r_py;
                n_sum  = SUM_W'(r_px);
                n_pt   = COUNT_WIDTH'(1);
                n_mean = r_px;
                n_acc  = 1'b1;
            end
            vwsf_pkg::OP_ADD: begin
                if (w_add_ok) begin
                    n_pt   = r_pt + COUNT_WIDTH'(1);
                    n_low  = (r_py < r_low) ? r_py : r_low;
                    n_high = (r_py > r_high) ? r_py : r_high;
                    n_sum  = w_sum_sat;
                    n_acc  = 1'b1;
                    n_div  = 1'b1;
                end
            end
            vwsf_pkg::OP_MERGE: begin
                if (w_merge_ok && !w_gap_bad) begin
                    n_pt   = w_cnt_sum[COUNT_WIDTH-1:0];
                    n_low  = (r_olo < r_low) ? r_olo : r_low;
                    n_high = (r_ohi > r_high) ? r_ohi : r_high;
                    n_sum  = w_sum_sat;
                    n_acc  = 1'b1;
                    n_div  = 1'b1;
                end
            end
            default: ;  // unused opcode leaves the segment alone
        endcase
    end

    // ------------------------------------------------------------------
    // shared restoring divider: |sum| / count, one bit a cycle
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]       r_dvd;     // dividend shifts out, quotient shifts in
    logic [COUNT_WIDTH-1:0] r_rem;
    logic                   r_neg;
    logic [COUNT_WIDTH:0]   w_trial;
    logic                   w_fits;
    logic signed [SUM_W:0]  w_quot;

    assign w_trial = {r_rem, r_dvd[SUM_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_pt});
    assign w_quot  = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});

    // ------------------------------------------------------------------
    // sparse-segment flag
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]         r_prod;
    logic signed [SMALL_W-1:0] w_len, w_prod, w_slen;
    logic                      w_small;

    always_comb begin
        w_len   = SMALL_W'(r_high) - SMALL_W'(r_low);
        w_prod  = SMALL_W'({1'b0, r_prod});
        w_slen  = SMALL_W'({1'b0, r_cfg[vwsf_pkg::CFG_SMALL_LEN]});
        w_small = (r_pt != '0) && (w_len < w_prod) && !(w_len > w_slen);
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
            r_sum  <= '0;
            r_pt   <= '0;
            r_mean <= '0;
            r_div  <= 1'b0;
            r_step <= '0;
        end else begin
            unique case (r_state)
                vwsf_pkg::ST_EVAL: begin
                    r_low  <= n_low;
                    r_high <= n_high;
                    r_sum  <= n_sum;
                    r_pt   <= n_pt;
                    r_mean <= n_mean;
                    r_div  <= n_div;
                    r_step <= '0;
                end
                vwsf_pkg::ST_DIVIDE: begin
                    r_step <= r_step + STEP_W'(1);
                end
                vwsf_pkg::ST_MULT: begin
                    // truncated quotient, clamped to the coordinate range
                    if (r_div) begin
                        if (w_quot > Q_MAX) begin
                            r_mean <= COORD_WIDTH'(Q_MAX);
                        end else if (w_quot < Q_MIN) begin
                            r_mean <= COORD_WIDTH'(Q_MIN);
                        end else begin
                            r_mean <= w_quot[COORD_WIDTH-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            vwsf_pkg::ST_EVAL: begin
                r_acc <= n_acc;
                r_neg <= n_sum[SUM_W-1];
                r_dvd <= n_sum[SUM_W-1] ? SUM_W'(-(SUM_W+1)'(n_sum)) : n_sum;
                r_rem <= '0;
            end
            vwsf_pkg::ST_DIVIDE: begin
                r_rem <= w_fits ? COUNT_WIDTH'(w_trial - {1'b0, r_pt})
                                : w_trial[COUNT_WIDTH-1:0];
                r_dvd <= {r_dvd[SUM_W-2:0], w_fits};
            end
            vwsf_pkg::ST_MULT: begin
                r_prod <= r_cfg[vwsf_pkg::CFG_SMALL_THR] * r_pt;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // result register, frees the sequencer while the beat waits
    // ------------------------------------------------------------------
    logic                          r_o_acc, r_o_small;
    logic signed [COORD_WIDTH-1:0] r_o_low, r_o_high, r_o_x;
    logic [COUNT_WIDTH-1:0]        r_o_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_acc   <= r_acc;
            r_o_low   <= r_low;
            r_o_high  <= r_high;
            r_o_x     <= r_mean;
            r_o_cnt   <= r_pt;
            r_o_small <= w_small;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.accepted   = r_o_acc;
    assign o_res.seg_low_y  = r_o_low;
    assign o_res.seg_high_y = r_o_high;
    assign o_res.seg_x      = r_o_x;
    assign o_res.seg_count  = r_o_cnt;
    assign o_res.is_small   = r_o_small;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // divider remainder stays below the divisor on every step
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vwsf_pkg::ST_DIVIDE) |-> (r_rem < r_pt))
        else $error("divider remainder not below point count");

    // the reported segment never has its ends crossed
    a_seg_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.seg_high_y >= o_res.seg_low_y))
        else $error("segment upper end below lower end");

    // an accepted beat always leaves a non-empty segment
    a_acc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.accepted) |-> (o_res.seg_count != '0))
        else $error("accepted result with empty segment");

endmodule
